FILE: rtl/min_max_stack_core_macros.svh
// Assertion macros for the min/max stack core.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef MIN_MAX_STACK_CORE_MACROS_SVH
`define MIN_MAX_STACK_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mms_pkg.sv
// Shared types and constants for the min/max stack core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mms_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned DEPTH_DEF = 128;

  localparam logic signed [DATA_W-1:0] INT_MIN     = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] TRACK_EMPTY = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // Per-stack operation strobes, at most one set per cycle.
  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
  } lifo_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/mms_if.sv
// Valid/ready channel interfaces for command beats and result beats.
// Depends on mms_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mms_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [mms_pkg::CMD_W-1:0]           command;
  logic signed [mms_pkg::DATA_W-1:0]   data;

  modport source (output valid, command, data, input ready);
  modport sink   (input valid, command, data, output ready);
endinterface

interface mms_res_if;
  logic                                valid;
  logic                                ready;
  logic [mms_pkg::STAT_W-1:0]          status;
  logic signed [mms_pkg::DATA_W-1:0]   popped_value;
  logic signed [mms_pkg::DATA_W-1:0]   top_value;
  logic signed [mms_pkg::DATA_W-1:0]   min_value;
  logic signed [mms_pkg::DATA_W-1:0]   max_value;
  logic [mms_pkg::COUNT_W-1:0]         count;
  logic                                is_empty;
  logic                                is_full;

  modport source (output valid, status, popped_value, top_value, min_value, max_value,
                  count, is_empty, is_full, input ready);
  modport sink   (input valid, status, popped_value, top_value, min_value, max_value,
                  count, is_empty, is_full, output ready);
endinterface

`default_nettype wire

FILE: rtl/mms_lifo.sv
// One LIFO: top two entries in flops, the rest in a RAM with registered read.
// Depends on mms_pkg and min_max_stack_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module mms_lifo #(
  parameter int unsigned DEPTH = mms_pkg::DEPTH_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire mms_pkg::lifo_ctl_t                    ctl_i,
  input  wire logic signed [mms_pkg::DATA_W-1:0]     data_i,
  output logic signed [mms_pkg::DATA_W-1:0]          top_o,
  output logic [$clog2(DEPTH+1)-1:0]                 cnt_o,
  output logic signed [mms_pkg::DATA_W-1:0]          nxt_top_o,
  output logic [$clog2(DEPTH+1)-1:0]                 nxt_cnt_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [CNT_W-1:0]                   cnt_q, cnt_d;
  logic signed [mms_pkg::DATA_W-1:0]  top_q, top_d;
  logic signed [mms_pkg::DATA_W-1:0]  sec_q, sec_d;
  logic signed [mms_pkg::DATA_W-1:0]  byp_q, byp_d;
  logic                               byp_vld_q, byp_vld_d;
  logic signed [mms_pkg::DATA_W-1:0]  rdata_q;
  logic signed [mms_pkg::DATA_W-1:0]  third;
  logic                               wr_en, rd_en;
  logic [AW-1:0]                      wr_addr, rd_addr;

  logic signed [mms_pkg::DATA_W-1:0]  mem [DEPTH];

  // Third entry from the top: either the word just spilled or the prefetched read.
  assign third = byp_vld_q ? byp_q : rdata_q;

  assign wr_addr = AW'(cnt_q - CNT_W'(2));
  assign rd_addr = AW'(cnt_q - CNT_W'(4));

  always_comb begin
    cnt_d     = cnt_q;
    top_d     = top_q;
    sec_d     = sec_q;
    byp_d     = byp_q;
    byp_vld_d = byp_vld_q;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    if (ctl_i.clr) begin
      cnt_d     = '0;
      byp_vld_d = 1'b0;
    end else if (ctl_i.push) begin
      cnt_d     = cnt_q + CNT_W'(1);
      top_d     = data_i;
      sec_d     = top_q;
      byp_d     = sec_q;
      byp_vld_d = 1'b1;
      wr_en     = (cnt_q >= CNT_W'(2));
    end else if (ctl_i.pop) begin
      cnt_d     = cnt_q - CNT_W'(1);
      top_d     = sec_q;
      sec_d     = third;
      byp_vld_d = 1'b0;
      rd_en     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      byp_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      byp_vld_q <= byp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    sec_q <= sec_d;
    byp_q <= byp_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= sec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign top_o     = top_q;
  assign cnt_o     = cnt_q;
  assign nxt_top_o = top_d;
  assign nxt_cnt_o = cnt_d;

`include "min_max_stack_core_macros.svh"

  `MMS_ASSERT_IMP(a_pop_nonempty, ctl_i.pop, cnt_q != '0, "pop on empty lifo")
  `MMS_ASSERT_IMP(a_push_notfull, ctl_i.push, cnt_q != CNT_W'(DEPTH), "push on full lifo")
  `MMS_ASSERT_IMP(a_one_op, 1'b1, $onehot0({ctl_i.push, ctl_i.pop, ctl_i.clr}),
                  "more than one lifo op")

endmodule

`default_nettype wire

FILE: rtl/min_max_stack_core.sv
// A result beat is registered and is valid in the cycle after its command beat is accepted.
// Throughput: one command per cycle; commands keep flowing while the result register
// holds an untaken beat as long as that beat is taken in the same cycle.
// Three LIFOs (values, min tracker, max tracker) each keep their top two words in flops.
// Reset clears all counts and the result valid; stack RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module min_max_stack_core #(
  parameter int unsigned DEPTH = mms_pkg::DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mms_cmd_if.sink    cmd_i,
  mms_res_if.source  res_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mms_pkg::cmd_e                      cmd;
  logic                               fire;
  logic                               val_full, val_empty;
  logic                               push_ok, pop_ok;
  logic signed [mms_pkg::DATA_W-1:0]  popped;
  mms_pkg::status_e                   status;
  mms_pkg::lifo_ctl_t                 val_ctl, min_ctl, max_ctl;

  logic signed [mms_pkg::DATA_W-1:0]  val_top, min_top, max_top;
  logic signed [mms_pkg::DATA_W-1:0]  val_nxt_top, min_nxt_top, max_nxt_top;
  logic [CNT_W-1:0]                   val_cnt, min_cnt, max_cnt;
  logic [CNT_W-1:0]                   val_nxt_cnt, min_nxt_cnt, max_nxt_cnt;

  logic                               res_vld_q;
  mms_pkg::status_e                   res_status_q;
  logic signed [mms_pkg::DATA_W-1:0]  res_popped_q, res_top_q, res_min_q, res_max_q;
  logic [mms_pkg::COUNT_W-1:0]        res_count_q;
  logic                               res_empty_q, res_full_q;

  assign cmd_i.ready = !res_vld_q || res_o.ready;
  assign fire        = cmd_i.valid && cmd_i.ready;
  assign cmd         = mms_pkg::cmd_e'(cmd_i.command);

  assign val_full  = (val_cnt == CNT_W'(DEPTH));
  assign val_empty = (val_cnt == '0);
  assign push_ok   = fire && (cmd == mms_pkg::CMD_PUSH) && !val_full;
  assign pop_ok    = fire && (cmd == mms_pkg::CMD_POP) && !val_empty;
  assign popped    = val_top;

  always_comb begin
    val_ctl     = '0;
    min_ctl     = '0;
    max_ctl     = '0;
    val_ctl.clr = fire && (cmd == mms_pkg::CMD_CLEAR);
    min_ctl.clr = val_ctl.clr;
    max_ctl.clr = val_ctl.clr;
    val_ctl.push = push_ok;
    min_ctl.push = push_ok && ((min_cnt == '0) || (cmd_i.data <= min_top));
    max_ctl.push = push_ok && ((max_cnt == '0) || (max_top <= cmd_i.data));
    val_ctl.pop  = pop_ok;
    // trackers compare against the value leaving the stack, not the new top
    min_ctl.pop  = pop_ok && (min_cnt != '0) && (min_top == popped);
    max_ctl.pop  = pop_ok && (max_cnt != '0) && (max_top == popped);
  end

  always_comb begin
    status = mms_pkg::ST_OK;
    case (cmd)
      mms_pkg::CMD_PUSH: if (val_full)  status = mms_pkg::ST_OVERFLOW;
      mms_pkg::CMD_POP:  if (val_empty) status = mms_pkg::ST_UNDERFLOW;
      default:           status = mms_pkg::ST_OK;
    endcase
  end

  mms_lifo #(.DEPTH(DEPTH)) u_val (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (val_ctl),
    .data_i    (cmd_i.data),
    .top_o     (val_top),
    .cnt_o     (val_cnt),
    .nxt_top_o (val_nxt_top),
    .nxt_cnt_o (val_nxt_cnt)
  );

  mms_lifo #(.DEPTH(DEPTH)) u_min (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (min_ctl),
    .data_i    (cmd_i.data),
    .top_o     (min_top),
    .cnt_o     (min_cnt),
    .nxt_top_o (min_nxt_top),
    .nxt_cnt_o (min_nxt_cnt)
  );

  mms_lifo #(.DEPTH(DEPTH)) u_max (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (max_ctl),
    .data_i    (cmd_i.data),
    .top_o     (max_top),
    .cnt_o     (max_cnt),
    .nxt_top_o (max_nxt_top),
    .nxt_cnt_o (max_nxt_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      res_vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_status_q <= status;
      res_popped_q <= pop_ok ? popped : mms_pkg::INT_MIN;
      res_top_q    <= (val_nxt_cnt != '0) ? val_nxt_top : mms_pkg::INT_MIN;
      res_min_q    <= (min_nxt_cnt != '0) ? min_nxt_top : mms_pkg::TRACK_EMPTY;
      res_max_q    <= (max_nxt_cnt != '0) ? max_nxt_top : mms_pkg::TRACK_EMPTY;
      res_count_q  <= mms_pkg::COUNT_W'(val_nxt_cnt);
      res_empty_q  <= (val_nxt_cnt == '0);
      res_full_q   <= (val_nxt_cnt == CNT_W'(DEPTH));
    end
  end

  assign res_o.valid        = res_vld_q;
  assign res_o.status       = res_status_q;
  assign res_o.popped_value = res_popped_q;
  assign res_o.top_value    = res_top_q;
  assign res_o.min_value    = res_min_q;
  assign res_o.max_value    = res_max_q;
  assign res_o.count        = res_count_q;
  assign res_o.is_empty     = res_empty_q;
  assign res_o.is_full      = res_full_q;

`include "min_max_stack_core_macros.svh"

  `MMS_ASSERT_IMP(a_min_le_val, 1'b1, min_cnt <= val_cnt, "min tracker deeper than stack")
  `MMS_ASSERT_IMP(a_max_le_val, 1'b1, max_cnt <= val_cnt, "max tracker deeper than stack")
  `MMS_ASSERT_IMP(a_trk_nonempty, val_cnt != '0, (min_cnt != '0) && (max_cnt != '0),
                  "tracker empty while stack holds entries")
  `MMS_ASSERT_NXT(a_clear_empties, fire && (cmd == mms_pkg::CMD_CLEAR),
                  (val_cnt == '0) && (min_cnt == '0) && (max_cnt == '0),
                  "clear left entries behind")

endmodule

`default_nettype wire
